// ===== rtl/iso_pkg.sv =====
// Package for the ISO 8601 timestamp parser: parse phases, status codes,
// record structs and small calendar tables. No dependencies.
package iso_pkg;

    localparam int unsigned MAX_YEAR_DIGITS = 5;
    localparam int unsigned FRACTION_DIGITS = 9;

    typedef enum logic [4:0] {
        PH_YSTART, PH_YDIG, PH_YPLUS, PH_DSEP1, PH_MON0, PH_MON1, PH_DSEP2,
        PH_DAY0, PH_DAY1, PH_DATEDONE, PH_HR0, PH_HR1, PH_HRDONE, PH_MI0, PH_MI1,
        PH_MIDONE, PH_SE0, PH_SE1, PH_SEDONE, PH_FRAC, PH_ZH0, PH_ZH1, PH_ZSEP,
        PH_ZM0, PH_ZM1, PH_ZDONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NON_DIGIT = 3'd1,
        ST_BAD_SEP   = 3'd2,
        ST_SHORT     = 3'd3,
        ST_MONTH     = 3'd4,
        ST_DAY       = 3'd5,
        ST_EXTRA     = 3'd6
    } status_t;

    // pipeline control from the top level
    typedef struct packed {
        logic accept;
        logic advance;
    } pipe_ctl_t;

    // parser state captured at the final character
    typedef struct packed {
        status_t     status;
        logic [16:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [29:0] frac;
        logic [3:0]  frac_digits;
        logic        zone_neg;
        logic [6:0]  zone_hour;
        logic [6:0]  zone_minute;
        logic        time_seen;
        logic        zone_seen;
    } snap_t;

    // first arithmetic stage
    typedef struct packed {
        status_t            status;
        logic [16:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [10:0]        cen;
        logic [29:0]        nanos;
        logic [18:0]        sod;
        logic signed [13:0] zone;
        logic               time_seen;
        logic               zone_seen;
    } stage1_t;

    // second arithmetic stage, input to the output register
    typedef struct packed {
        status_t            status;
        logic [16:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [10:0]        cen;
        logic [8:0]         doy;
        logic [15:0]        cen_days;
        logic [29:0]        nanos;
        logic [18:0]        sod;
        logic signed [13:0] zone;
        logic               time_seen;
        logic               zone_seen;
    } stage2_t;

    function automatic logic [8:0] cum_days(input logic [3:0] m);
        case (m)
            4'd0:    cum_days = 9'd0;
            4'd1:    cum_days = 9'd31;
            4'd2:    cum_days = 9'd59;
            4'd3:    cum_days = 9'd90;
            4'd4:    cum_days = 9'd120;
            4'd5:    cum_days = 9'd151;
            4'd6:    cum_days = 9'd181;
            4'd7:    cum_days = 9'd212;
            4'd8:    cum_days = 9'd243;
            4'd9:    cum_days = 9'd273;
            4'd10:   cum_days = 9'd304;
            4'd11:   cum_days = 9'd334;
            4'd12:   cum_days = 9'd365;
            default: cum_days = 9'd0;
        endcase
    endfunction

    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
        case (m)
            4'd2:                      days_in_month = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   days_in_month = 5'd30;
            default:                   days_in_month = 5'd31;
        endcase
    endfunction

    function automatic logic [29:0] pow_ten(input logic [3:0] k);
        case (k)
            4'd0:    pow_ten = 30'd1;
            4'd1:    pow_ten = 30'd10;
            4'd2:    pow_ten = 30'd100;
            4'd3:    pow_ten = 30'd1000;
            4'd4:    pow_ten = 30'd10000;
            4'd5:    pow_ten = 30'd100000;
            4'd6:    pow_ten = 30'd1000000;
            4'd7:    pow_ten = 30'd10000000;
            4'd8:    pow_ten = 30'd100000000;
            4'd9:    pow_ten = 30'd1000000000;
            default: pow_ten = 30'd0;
        endcase
    endfunction

    // two-digit field accumulate, kept to 7 bits
    function automatic logic [6:0] acc2(input logic [6:0] acc, input logic [3:0] d);
        logic [10:0] t;
        t = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {7'd0, d};
        acc2 = t[6:0];
    endfunction

endpackage

// ===== rtl/iso_char_parser.sv =====
// Character-level parser: phase state, field accumulators, first-error code.
// Captures a snapshot at the final character. Depends on iso_pkg.
module iso_char_parser
    import iso_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pipe_ctl_t ctl,
    input  logic [7:0] char_code,
    input  logic      final_char,
    output logic      snap_valid,
    output snap_t     snap
);

    phase_t      phase_reg, phase_next;
    logic [5:0]  index_reg, index_next;
    logic [16:0] year_reg, year_next;
    logic [2:0]  ydig_reg, ydig_next;
    logic [6:0]  mon_reg, mon_next, day_reg, day_next;
    logic [6:0]  hr_reg, hr_next, mi_reg, mi_next, se_reg, se_next;
    logic [29:0] frac_reg, frac_next;
    logic [3:0]  fdig_reg, fdig_next;
    logic        zneg_reg, zneg_next;
    logic [6:0]  zh_reg, zh_next, zm_reg, zm_next;
    status_t     err_reg, err_next;

    // leap flag of the held year, derived from the year accumulator through cen_reg and leap_reg
    logic [10:0] cen_reg;
    logic        leap_reg;
    logic [37:0] cen_prod;
    logic [16:0] cen_x100;

    logic        snap_valid_reg;
    snap_t       snap_reg, snap_next;

    logic        dig, sign, ok_end;
    logic [3:0]  d;
    logic [20:0] year_x10;
    logic [4:0]  maxd;
    status_t     status_c;

    assign cen_prod = {4'd0, year_reg} * 38'd1342178;
    assign cen_x100 = 17'(cen_reg) * 17'd100;

    always_comb
    begin
        dig      = (char_code >= 8'h30) && (char_code <= 8'h39);
        d        = dig ? 4'(char_code - 8'h30) : 4'd0;
        sign     = (char_code == 8'h2B) || (char_code == 8'h2D);
        year_x10 = {1'b0, year_reg, 3'b000} + {3'b000, year_reg, 1'b0} + {17'd0, d};
        maxd     = days_in_month(mon_reg[3:0], leap_reg);

        phase_next = phase_reg;
        index_next = (index_reg != 6'd63) ? index_reg + 6'd1 : index_reg;
        year_next  = year_reg;
        ydig_next  = ydig_reg;
        mon_next   = mon_reg;
        day_next   = day_reg;
        hr_next    = hr_reg;
        mi_next    = mi_reg;
        se_next    = se_reg;
        frac_next  = frac_reg;
        fdig_next  = fdig_reg;
        zneg_next  = zneg_reg;
        zh_next    = zh_reg;
        zm_next    = zm_reg;
        err_next   = err_reg;

        if (err_reg == ST_OK)
        begin
            case (phase_reg)
                PH_YSTART:
                begin
                    if (char_code == 8'h2B)
                        phase_next = PH_YPLUS;
                    else if (dig)
                    begin
                        year_next  = {13'd0, d};
                        ydig_next  = 3'd1;
                        phase_next = PH_YDIG;
                    end
                    else
                        err_next = ST_NON_DIGIT;
                end
                PH_YDIG:
                begin
                    if (!dig)
                        err_next = ST_NON_DIGIT;
                    else
                    begin
                        year_next = year_x10[16:0];
                        ydig_next = ydig_reg + 3'd1;
                        if (ydig_reg + 3'd1 >= 3'd4)
                            phase_next = PH_DSEP1;
                    end
                end
                PH_YPLUS:
                begin
                    if (dig)
                    begin
                        if (ydig_reg >= 3'(MAX_YEAR_DIGITS))
                            err_next = ST_BAD_SEP;
                        else
                        begin
                            year_next = year_x10[16:0];
                            ydig_next = ydig_reg + 3'd1;
                        end
                    end
                    else if (char_code == 8'h2D)
                        phase_next = PH_MON0;
                    else
                        err_next = ST_BAD_SEP;
                end
                PH_DSEP1, PH_DSEP2:
                begin
                    if (char_code != 8'h2D)
                        err_next = ST_BAD_SEP;
                    else
                        phase_next = (phase_reg == PH_DSEP1) ? PH_MON0 : PH_DAY0;
                end
                PH_MON0, PH_MON1, PH_DAY0, PH_DAY1, PH_HR0, PH_HR1, PH_MI0, PH_MI1,
                PH_SE0, PH_SE1, PH_ZH0, PH_ZH1, PH_ZM0, PH_ZM1:
                begin
                    if (!dig)
                        err_next = ST_NON_DIGIT;
                    else
                    begin
                        case (phase_reg)
                            PH_MON0: begin mon_next = acc2(mon_reg, d); phase_next = PH_MON1; end
                            PH_MON1: begin mon_next = acc2(mon_reg, d); phase_next = PH_DSEP2; end
                            PH_DAY0: begin day_next = acc2(day_reg, d); phase_next = PH_DAY1; end
                            PH_DAY1:
                            begin
                                day_next = acc2(day_reg, d);
                                if ((mon_reg < 7'd1) || (mon_reg > 7'd12))
                                    err_next = ST_MONTH;
                                else if ((day_next < 7'd1) || (day_next > {2'b00, maxd}))
                                    err_next = ST_DAY;
                                else
                                    phase_next = PH_DATEDONE;
                            end
                            PH_HR0:  begin hr_next = acc2(hr_reg, d); phase_next = PH_HR1; end
                            PH_HR1:  begin hr_next = acc2(hr_reg, d); phase_next = PH_HRDONE; end
                            PH_MI0:  begin mi_next = acc2(mi_reg, d); phase_next = PH_MI1; end
                            PH_MI1:  begin mi_next = acc2(mi_reg, d); phase_next = PH_MIDONE; end
                            PH_SE0:  begin se_next = acc2(se_reg, d); phase_next = PH_SE1; end
                            PH_SE1:  begin se_next = acc2(se_reg, d); phase_next = PH_SEDONE; end
                            PH_ZH0:  begin zh_next = acc2(zh_reg, d); phase_next = PH_ZH1; end
                            PH_ZH1:  begin zh_next = acc2(zh_reg, d); phase_next = PH_ZSEP; end
                            PH_ZM0:  begin zm_next = acc2(zm_reg, d); phase_next = PH_ZM1; end
                            default: begin zm_next = acc2(zm_reg, d); phase_next = PH_ZDONE; end
                        endcase
                    end
                end
                PH_DATEDONE:
                begin
                    if (char_code == 8'h54)
                        phase_next = PH_HR0;
                    else
                        err_next = ST_BAD_SEP;
                end
                PH_HRDONE, PH_MIDONE:
                begin
                    if (char_code != 8'h3A)
                        err_next = ST_BAD_SEP;
                    else
                        phase_next = (phase_reg == PH_HRDONE) ? PH_MI0 : PH_SE0;
                end
                PH_SEDONE, PH_FRAC:
                begin
                    if ((char_code == 8'h2E) && (phase_reg == PH_SEDONE))
                        phase_next = PH_FRAC;
                    else if (dig && (phase_reg == PH_FRAC))
                    begin
                        if (fdig_reg < 4'(FRACTION_DIGITS))
                        begin
                            frac_next = 30'({frac_reg, 3'b000} + {2'b00, frac_reg, 1'b0})
                                        + {26'd0, d};
                            fdig_next = fdig_reg + 4'd1;
                        end
                    end
                    else if (sign)
                    begin
                        zneg_next  = (char_code == 8'h2D);
                        phase_next = PH_ZH0;
                    end
                    else
                        err_next = ST_EXTRA;
                end
                PH_ZSEP:
                begin
                    if (char_code == 8'h3A)
                        phase_next = PH_ZM0;
                    else if (dig)
                    begin
                        zm_next    = {3'd0, d};
                        phase_next = PH_ZM1;
                    end
                    else
                        err_next = ST_NON_DIGIT;
                end
                default:
                    err_next = ST_EXTRA;
            endcase
        end

        ok_end = (phase_next == PH_DATEDONE) || (phase_next == PH_HRDONE) ||
                 (phase_next == PH_MIDONE) || (phase_next == PH_SEDONE) ||
                 (phase_next == PH_FRAC) || (phase_next == PH_ZDONE);
        if (index_next < 6'd10)
            status_c = ST_SHORT;
        else if (err_next != ST_OK)
            status_c = err_next;
        else if (!ok_end)
            status_c = ST_SHORT;
        else
            status_c = ST_OK;

        snap_next.status      = status_c;
        snap_next.year        = year_next;
        snap_next.month       = mon_next[3:0];
        snap_next.day         = day_next[4:0];
        snap_next.hour        = hr_next;
        snap_next.minute      = mi_next;
        snap_next.second      = se_next;
        snap_next.frac        = frac_next;
        snap_next.frac_digits = fdig_next;
        snap_next.zone_neg    = zneg_next;
        snap_next.zone_hour   = zh_next;
        snap_next.zone_minute = zm_next;
        snap_next.time_seen   = (phase_next >= PH_HRDONE);
        snap_next.zone_seen   = (phase_next == PH_ZDONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_YSTART;
            index_reg <= '0;
            year_reg  <= '0;
            ydig_reg  <= '0;
            mon_reg   <= '0;
            day_reg   <= '0;
            hr_reg    <= '0;
            mi_reg    <= '0;
            se_reg    <= '0;
            frac_reg  <= '0;
            fdig_reg  <= '0;
            zneg_reg  <= 1'b0;
            zh_reg    <= '0;
            zm_reg    <= '0;
            err_reg   <= ST_OK;
            cen_reg   <= '0;
            leap_reg  <= 1'b1;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            cen_reg  <= cen_prod[37:27];
            leap_reg <= (year_reg == cen_x100) ? (cen_reg[1:0] == 2'd0)
                                                : (year_reg[1:0] == 2'd0);
            if (ctl.accept)
            begin
                if (final_char)
                begin
                    phase_reg <= PH_YSTART;
                    index_reg <= '0;
                    year_reg  <= '0;
                    ydig_reg  <= '0;
                    mon_reg   <= '0;
                    day_reg   <= '0;
                    hr_reg    <= '0;
                    mi_reg    <= '0;
                    se_reg    <= '0;
                    frac_reg  <= '0;
                    fdig_reg  <= '0;
                    zneg_reg  <= 1'b0;
                    zh_reg    <= '0;
                    zm_reg    <= '0;
                    err_reg   <= ST_OK;
                end
                else
                begin
                    phase_reg <= phase_next;
                    index_reg <= index_next;
                    year_reg  <= year_next;
                    ydig_reg  <= ydig_next;
                    mon_reg   <= mon_next;
                    day_reg   <= day_next;
                    hr_reg    <= hr_next;
                    mi_reg    <= mi_next;
                    se_reg    <= se_next;
                    frac_reg  <= frac_next;
                    fdig_reg  <= fdig_next;
                    zneg_reg  <= zneg_next;
                    zh_reg    <= zh_next;
                    zm_reg    <= zm_next;
                    err_reg   <= err_next;
                end
            end
            if (ctl.advance)
                snap_valid_reg <= ctl.accept && final_char;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
            snap_reg <= snap_next;
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

// ===== rtl/iso_record_calc.sv =====
// Two arithmetic stages: century split, time, fraction scale and zone,
// then year remainder, day of year and days within the century.
// Depends on iso_pkg.
module iso_record_calc
    import iso_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pipe_ctl_t ctl,
    input  logic      snap_valid,
    input  snap_t     snap,
    output logic      s2_valid,
    output stage2_t   s2
);

    logic    s1_valid_reg, s2_valid_reg;
    stage1_t s1_reg, s1_next;
    stage2_t s2_reg, s2_next;

    logic [37:0] cen_prod;
    logic [59:0] frac_prod;
    logic [12:0] zmag;
    logic [16:0] cen_x100;
    logic [6:0]  yic;
    logic        leap;

    always_comb
    begin
        // year / 100 by reciprocal, exact for every 17-bit year
        cen_prod  = {4'd0, snap.year} * 38'd1342178;
        frac_prod = {30'd0, snap.frac} * {30'd0, pow_ten(4'd9 - snap.frac_digits)};
        zmag      = 13'(snap.zone_hour) * 13'd60 + 13'(snap.zone_minute);

        s1_next.status    = snap.status;
        s1_next.year      = snap.year;
        s1_next.month     = snap.month;
        s1_next.day       = snap.day;
        s1_next.cen       = cen_prod[37:27];
        s1_next.nanos     = frac_prod[29:0];
        s1_next.sod       = 19'(snap.hour) * 19'd3600 + 19'(snap.minute) * 19'd60
                            + 19'(snap.second);
        s1_next.zone      = snap.zone_neg ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});
        s1_next.time_seen = snap.time_seen;
        s1_next.zone_seen = snap.zone_seen;
    end

    always_comb
    begin
        cen_x100 = 17'(s1_reg.cen) * 17'd100;
        yic      = 7'(s1_reg.year - cen_x100);
        leap     = (yic == 7'd0) ? (s1_reg.cen[1:0] == 2'd0) : (yic[1:0] == 2'd0);

        s2_next.status    = s1_reg.status;
        s2_next.year      = s1_reg.year;
        s2_next.month     = s1_reg.month;
        s2_next.day       = s1_reg.day;
        s2_next.cen       = s1_reg.cen;
        s2_next.doy       = cum_days(s1_reg.month - 4'd1) + 9'(s1_reg.day) - 9'd1
                            + 9'(((s1_reg.month > 4'd2) && leap) ? 1 : 0);
        s2_next.cen_days  = 16'(yic) * 16'd365;
        if (yic != 7'd0)
            s2_next.cen_days = s2_next.cen_days + 16'((yic - 7'd1) >> 2)
                               + 16'((s1_reg.cen[1:0] == 2'd0) ? 1 : 0);
        s2_next.nanos     = s1_reg.nanos;
        s2_next.sod       = s1_reg.sod;
        s2_next.zone      = s1_reg.zone;
        s2_next.time_seen = s1_reg.time_seen;
        s2_next.zone_seen = s1_reg.zone_seen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            s1_valid_reg <= snap_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2       = s2_reg;

endmodule

// ===== rtl/iso8601_timestamp_parser.sv =====
// A record passes the snapshot register, two arithmetic stages and the output register.
// Throughput: one character item per cycle; the parser state register takes
// a character at every edge the output side does not stall.
// The whole pipeline holds while a finished record waits on out_stall.
// Reset (rst_n low, asynchronous) empties the pipeline and puts the parser
// at the start of the year field with all accumulators cleared.
module iso8601_timestamp_parser
    import iso_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         char_code,
    input  logic               final_char,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [16:0]        year_value,
    output logic [3:0]         month_value,
    output logic [4:0]         day_value,
    output logic [8:0]         ordinal_day,
    output logic [25:0]        epoch_day,
    output logic [18:0]        seconds_of_day,
    output logic [29:0]        nanoseconds,
    output logic signed [13:0] zone_minutes,
    output logic               time_seen,
    output logic               zone_seen
);

    pipe_ctl_t ctl;
    logic      snap_valid, s2_valid;
    snap_t     snap;
    stage2_t   s2;

    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic [16:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [8:0]  doy_reg;
    logic [25:0] epoch_reg, epoch_next;
    logic [18:0] sod_reg;
    logic [29:0] nanos_reg;
    logic signed [13:0] zone_reg;
    logic        ts_reg, zs_reg;
    logic        ok;
    logic [26:0] epoch_sum;

    // every stage moves together; a stalled output freezes all of them
    assign ctl.advance = !out_valid_reg || !out_stall;
    assign ctl.accept  = in_valid && ctl.advance;
    assign in_stall    = !ctl.advance;

    iso_char_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .char_code  (char_code),
        .final_char (final_char),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    iso_record_calc u_calc (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .snap_valid (snap_valid),
        .snap       (snap),
        .s2_valid   (s2_valid),
        .s2         (s2)
    );

    // day count: 400-year blocks, then centuries (each after the first of a
    // block is one day short), then the days inside the century
    always_comb
    begin
        ok         = (s2.status == ST_OK);
        epoch_sum  = 27'(s2.cen[10:2]) * 27'd146097 + 27'(s2.cen[1:0]) * 27'd36524
                     + 27'((s2.cen[1:0] != 2'd0) ? 1 : 0) + 27'(s2.cen_days) + 27'(s2.doy);
        epoch_next = epoch_sum[25:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.advance)
            out_valid_reg <= s2_valid;
    end

    // an error record carries zeros in every field but the status
    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            status_reg <= s2.status;
            year_reg   <= ok ? s2.year      : '0;
            month_reg  <= ok ? s2.month     : '0;
            day_reg    <= ok ? s2.day       : '0;
            doy_reg    <= ok ? s2.doy       : '0;
            epoch_reg  <= ok ? epoch_next   : '0;
            sod_reg    <= ok ? s2.sod       : '0;
            nanos_reg  <= ok ? s2.nanos     : '0;
            zone_reg   <= ok ? s2.zone      : '0;
            ts_reg     <= ok && s2.time_seen;
            zs_reg     <= ok && s2.zone_seen;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign year_value     = year_reg;
    assign month_value    = month_reg;
    assign day_value      = day_reg;
    assign ordinal_day    = doy_reg;
    assign epoch_day      = epoch_reg;
    assign seconds_of_day = sod_reg;
    assign nanoseconds    = nanos_reg;
    assign zone_minutes   = zone_reg;
    assign time_seen      = ts_reg;
    assign zone_seen      = zs_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |->
            (year_value == 17'd0) && (epoch_day == 26'd0) && !time_seen && !zone_seen)
        else $error("error record with nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK) |->
            (month_value >= 4'd1) && (month_value <= 4'd12) && (day_value >= 5'd1))
        else $error("good record with date out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK) |-> (ordinal_day <= 9'd365))
        else $error("day of year out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zone_seen |-> time_seen)
        else $error("zone without time part");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output register");

endmodule

// ===== tb/tb.sv =====
// Testbench for iso8601_timestamp_parser: streams timestamp text one character
// per item and checks every record against a parser written here.
// Depends on rtl/iso_pkg.sv and rtl/iso8601_timestamp_parser.sv.
`timescale 1ns / 100ps

import iso_pkg::*;

// one parsed record, at the widths of the output ports
typedef struct {
    logic [2:0]         status;
    logic [16:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [8:0]         doy;
    logic [25:0]        epoch;
    logic [18:0]        sod;
    logic [29:0]        nanos;
    logic signed [13:0] zone;
    logic               time_seen;
    logic               zone_seen;
} record_t;

class timestamp_checker;
    phase_t      ph;
    int unsigned n_chars, yr, yr_digits, mon, dy, hr, mi, se;
    int unsigned frac, frac_digits, z_neg, z_hr, z_mi;
    logic [2:0]  err;
    record_t     pending_records[$];
    int          mismatches;

    function new();
        mismatches = 0;
        clear();
    endfunction

    function void clear();
        ph = PH_YSTART;
        n_chars = 0; yr = 0; yr_digits = 0; mon = 0; dy = 0;
        hr = 0; mi = 0; se = 0; frac = 0; frac_digits = 0;
        z_neg = 0; z_hr = 0; z_mi = 0;
        err = ST_OK;
    endfunction

    function int unsigned days_before(int unsigned m);
        int unsigned tbl[13];
        tbl = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
        return tbl[m];
    endfunction

    function bit leap_year(int unsigned y);
        if (y % 100 != 0)
            return (y % 100) % 4 == 0;
        return (y / 100) % 4 == 0;
    endfunction

    function int unsigned two_digit(int unsigned a, int unsigned d);
        return (a * 10 + d) & 'h7f;
    endfunction

    function void date_check();
        int unsigned maxd;
        if (mon < 1 || mon > 12) begin
            err = ST_MONTH;
            return;
        end
        maxd = days_before(mon) - days_before(mon - 1);
        if (mon == 2 && leap_year(yr))
            maxd++;
        if (dy < 1 || dy > maxd) begin
            err = ST_DAY;
            return;
        end
        ph = PH_DATEDONE;
    endfunction

    function void parse_char(logic [7:0] c);
        bit          dig;
        bit          sgn;
        int unsigned d;
        dig = c >= "0" && c <= "9";
        d   = dig ? c - "0" : 0;
        sgn = c == "+" || c == "-";
        case (ph)
            PH_YSTART:
                if (c == "+") ph = PH_YPLUS;
                else if (dig)
                begin
                    yr = d; yr_digits = 1; ph = PH_YDIG;
                end
                else err = ST_NON_DIGIT;
            PH_YDIG:
                if (!dig) err = ST_NON_DIGIT;
                else
                begin
                    yr = yr * 10 + d;
                    yr_digits++;
                    if (yr_digits >= 4) ph = PH_DSEP1;
                end
            PH_YPLUS:
                if (dig)
                begin
                    if (yr_digits >= MAX_YEAR_DIGITS) err = ST_BAD_SEP;
                    else
                    begin
                        yr = (yr * 10 + d) & 'h1ffff;
                        yr_digits++;
                    end
                end
                else if (c == "-") ph = PH_MON0;
                else err = ST_BAD_SEP;
            PH_DSEP1, PH_DSEP2:
                if (c != "-") err = ST_BAD_SEP;
                else ph = (ph == PH_DSEP1) ? PH_MON0 : PH_DAY0;
            PH_MON0, PH_MON1, PH_DAY0, PH_DAY1, PH_HR0, PH_HR1, PH_MI0, PH_MI1,
            PH_SE0, PH_SE1, PH_ZH0, PH_ZH1, PH_ZM0, PH_ZM1:
                if (!dig) err = ST_NON_DIGIT;
                else
                begin
                    case (ph)
                        PH_MON0, PH_MON1: mon  = two_digit(mon, d);
                        PH_DAY0, PH_DAY1: dy   = two_digit(dy, d);
                        PH_HR0, PH_HR1:   hr   = two_digit(hr, d);
                        PH_MI0, PH_MI1:   mi   = two_digit(mi, d);
                        PH_SE0, PH_SE1:   se   = two_digit(se, d);
                        PH_ZH0, PH_ZH1:   z_hr = two_digit(z_hr, d);
                        default:          z_mi = two_digit(z_mi, d);
                    endcase
                    if (ph == PH_DAY1) date_check();
                    else if (ph == PH_MON1) ph = PH_DSEP2;
                    else ph = phase_t'(ph + 1);
                end
            PH_DATEDONE:
                if (c == "T") ph = PH_HR0;
                else err = ST_BAD_SEP;
            PH_HRDONE, PH_MIDONE:
                if (c != ":") err = ST_BAD_SEP;
                else ph = (ph == PH_HRDONE) ? PH_MI0 : PH_SE0;
            PH_SEDONE, PH_FRAC:
                if (c == "." && ph == PH_SEDONE) ph = PH_FRAC;
                else if (dig && ph == PH_FRAC)
                begin
                    if (frac_digits < FRACTION_DIGITS)
                    begin
                        frac = frac * 10 + d;
                        frac_digits++;
                    end
                end
                else if (sgn)
                begin
                    z_neg = (c == "-");
                    ph = PH_ZH0;
                end
                else err = ST_EXTRA;
            PH_ZSEP:
                if (c == ":") ph = PH_ZM0;
                else if (dig)
                begin
                    z_mi = d; ph = PH_ZM1;
                end
                else err = ST_NON_DIGIT;
            default:
                err = ST_EXTRA;
        endcase
    endfunction

    // accepted character: advance the parser, queue a record on the last one
    function void note_char(logic [7:0] c, logic fin);
        record_t         r;
        bit              ok_end;
        bit              lp;
        int unsigned     cen, yic, doy, cen_days, zm;
        longint unsigned epoch, p10;
        if (n_chars < 63) n_chars++;
        if (err == ST_OK) parse_char(c);
        if (!fin) return;
        r = '{default: 0};
        ok_end = ph inside {PH_DATEDONE, PH_HRDONE, PH_MIDONE, PH_SEDONE,
                            PH_FRAC, PH_ZDONE};
        if (n_chars < 10) r.status = ST_SHORT;
        else if (err != ST_OK) r.status = err;
        else if (!ok_end) r.status = ST_SHORT;
        else r.status = ST_OK;
        if (r.status == ST_OK)
        begin
            lp  = leap_year(yr);
            cen = yr / 100;
            yic = yr % 100;
            doy = days_before(mon - 1) + dy - 1 + ((mon > 2 && lp) ? 1 : 0);
            cen_days = 365 * yic;
            if (yic > 0) cen_days += (yic - 1) / 4 + ((cen % 4 == 0) ? 1 : 0);
            epoch = 64'd146097 * (cen / 4) + 64'd36524 * (cen % 4)
                  + ((cen % 4 != 0) ? 1 : 0) + cen_days + doy;
            p10 = 1;
            repeat (9 - frac_digits) p10 *= 10;
            zm = z_hr * 60 + z_mi;
            r.year  = 17'(yr);
            r.month = 4'(mon);
            r.day   = 5'(dy);
            r.doy   = 9'(doy);
            r.epoch = 26'(epoch);
            r.sod   = 19'(hr * 3600 + mi * 60 + se);
            r.nanos = 30'(frac * p10);
            r.zone  = 14'(z_neg ? -zm : zm);
            r.time_seen = ph >= PH_HRDONE;
            r.zone_seen = ph == PH_ZDONE;
        end
        pending_records.push_back(r);
        clear();
    endfunction

    task report_mismatch(string what, longint got, longint want);
        $display("%0t: MISMATCH %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task check_record(record_t got);
        record_t w;
        if (pending_records.size() == 0)
        begin
            report_mismatch("unexpected record, status", got.status, 0);
            return;
        end
        w = pending_records.pop_front();
        if (got.status !== w.status) report_mismatch("status", got.status, w.status);
        if (got.year !== w.year) report_mismatch("year", got.year, w.year);
        if (got.month !== w.month) report_mismatch("month", got.month, w.month);
        if (got.day !== w.day) report_mismatch("day", got.day, w.day);
        if (got.doy !== w.doy) report_mismatch("ordinal_day", got.doy, w.doy);
        if (got.epoch !== w.epoch) report_mismatch("epoch_day", got.epoch, w.epoch);
        if (got.sod !== w.sod) report_mismatch("seconds_of_day", got.sod, w.sod);
        if (got.nanos !== w.nanos) report_mismatch("nanoseconds", got.nanos, w.nanos);
        if (got.zone !== w.zone) report_mismatch("zone_minutes", got.zone, w.zone);
        if (got.time_seen !== w.time_seen)
            report_mismatch("time_seen", got.time_seen, w.time_seen);
        if (got.zone_seen !== w.zone_seen)
            report_mismatch("zone_seen", got.zone_seen, w.zone_seen);
    endtask
endclass

module tb;
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         char_code;
    logic               final_char;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         status;
    logic [16:0]        year_value;
    logic [3:0]         month_value;
    logic [4:0]         day_value;
    logic [8:0]         ordinal_day;
    logic [25:0]        epoch_day;
    logic [18:0]        seconds_of_day;
    logic [29:0]        nanoseconds;
    logic signed [13:0] zone_minutes;
    logic               time_seen;
    logic               zone_seen;

    localparam int QUIET_LIMIT = 5000;   // cycles with no item moving either way

    timestamp_checker chk = new();
    int  send_gap_pct;    // chance per cycle that the sender holds off
    int  stall_pct;       // chance per cycle that the receiver stalls
    int  quiet_cycles;
    int  chars_sent;

    iso8601_timestamp_parser u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .char_code(char_code), .final_char(final_char),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .year_value(year_value), .month_value(month_value),
        .day_value(day_value), .ordinal_day(ordinal_day), .epoch_day(epoch_day),
        .seconds_of_day(seconds_of_day), .nanoseconds(nanoseconds),
        .zone_minutes(zone_minutes), .time_seen(time_seen), .zone_seen(zone_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Monitor: sampled in the active region right after the edge, so values
    // seen here are the ones the block saw at this edge. Also drives out_stall
    // and runs the no-progress watchdog.
    always @(posedge clk)
    begin
        record_t r;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                chk.note_char(char_code, final_char);
            if (out_valid && !out_stall)
            begin
                r.status = status; r.year = year_value; r.month = month_value;
                r.day = day_value; r.doy = ordinal_day; r.epoch = epoch_day;
                r.sod = seconds_of_day; r.nanos = nanoseconds;
                r.zone = zone_minutes; r.time_seen = time_seen;
                r.zone_seen = zone_seen;
                chk.check_record(r);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // One item; valid stays up when the next item follows directly.
    task send_char(input logic [7:0] c, input logic fin);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        char_code  <= c;
        final_char <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        chars_sent++;
    endtask

    // valid is dropped by the caller when no text follows directly
    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    // hold the sender until every expected record has come out
    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk.pending_records.size() != 0)
            @(posedge clk);
    endtask

    function string digits(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, $sformatf("%0d", $urandom_range(9))};
        return s;
    endfunction

    // mostly well-formed timestamps with random content, some broken
    function string random_stamp();
        string s;
        int    m, d, k, maxd;
        if ($urandom_range(99) < 5)
        begin
            s = "";
            repeat ($urandom_range(1, 16)) s = {s, string'(byte'($urandom_range(255)))};
            return s;
        end
        if ($urandom_range(99) < 75) s = digits(4);
        else s = {"+", digits($urandom_range(0, 6))};
        m = ($urandom_range(99) < 90) ? $urandom_range(1, 12) : $urandom_range(0, 99);
        maxd = (m == 2) ? 29 : (m == 4 || m == 6 || m == 9 || m == 11) ? 30 : 31;
        d = ($urandom_range(99) < 90) ? $urandom_range(1, maxd) : $urandom_range(0, 99);
        s = {s, $sformatf("-%02d-%02d", m, d)};
        k = $urandom_range(5);
        if (k >= 1) s = {s, "T", digits(2)};
        if (k >= 2) s = {s, ":", digits(2)};
        if (k >= 3) s = {s, ":", digits(2)};
        if (k >= 4 && $urandom_range(1)) s = {s, ".", digits($urandom_range(0, 12))};
        if (k >= 4 && $urandom_range(3) != 0)
        begin
            if ($urandom_range(1)) s = {s, "+"};
            else s = {s, "-"};
            s = {s, digits(2)};
            if ($urandom_range(1)) s = {s, ":"};
            s = {s, digits(2)};
        end
        case ($urandom_range(9))
            0: s[$urandom_range(s.len() - 1)] = byte'($urandom_range(255));
            1: s = s.substr(0, $urandom_range(s.len() - 1));
            2: s = {s, string'(byte'($urandom_range(32, 126)))};
            default: ;
        endcase
        return s;
    endfunction

    initial
    begin
        string directed[$];
        int    base;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        char_code    = 8'd0;
        final_char   = 1'b0;
        out_stall    = 1'b0;
        send_gap_pct = 0;
        stall_pct    = 0;
        quiet_cycles = 0;
        chars_sent   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // leap rules, each separator and error, long fraction, both zone forms,
        // plus-year extremes, short text and text ending inside a field
        directed = '{"2024-02-29", "1900-02-29", "2000-02-29T23:59:59.1234567891234+05:30",
                     "0000-01-01", "+-01-01T00", "+99999-12-31T99:99:99.9-9999",
                     "+123456-01-01", "+131071-12-31", "2023-13-01", "2023-04-31",
                     "abcdefghijk", "2023x01-01", "2023-01-01X", "2023-01-01T12-30",
                     "2023-01-01T12:30:00Z", "2023-01-01T12:3", "2023-01-01T1:30",
                     "2023-01-01T12:30:00+05", "2023-01-01T12:30:00-0530", "12",
                     "2100-12-31T00:00:00.", "\xff\x80\x7f-00-00"};
        foreach (directed[i]) send_text(directed[i]);
        drain();

        // random part in three idling regimes
        base = chars_sent;
        for (int p = 0; p < 3; p++)
        begin
            send_gap_pct = (p == 0) ? 19 : (p == 1) ? 56 : 0;
            stall_pct    = (p == 0) ? 56 : (p == 1) ? 19 : 0;
            while (chars_sent < base + 350 * (p + 1))
            begin
                send_text(random_stamp());
                if ($urandom_range(99) < 3)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                end
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (chk.mismatches == 0 && chk.pending_records.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== iso8601_timestamp_parser.f =====
rtl/iso_pkg.sv
rtl/iso_char_parser.sv
rtl/iso_record_calc.sv
rtl/iso8601_timestamp_parser.sv
tb/tb.sv
